// ===== rtl/psg_pkg.sv =====
// Shared types and constants for the three-voice sound generator core.
// Used by psg_env_step and psg_tone_noise_envelope_core; depends on nothing.
`default_nettype none

package psg_pkg;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_TICK  = 1'b1
    } t_func;

    localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
    localparam logic [3:0] REG_MIXER        = 4'd7;
    localparam logic [3:0] REG_VOL_A        = 4'd8;
    localparam logic [3:0] REG_VOL_B        = 4'd9;
    localparam logic [3:0] REG_VOL_C        = 4'd10;
    localparam logic [3:0] REG_ENV_FINE     = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE   = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;

    localparam int unsigned NUM_REGS  = 16;
    localparam int unsigned NUM_TONES = 3;

    localparam logic [16:0] LFSR_RESET = 17'h1FFFF;
    localparam logic [4:0]  ENV_TOP    = 5'h1F;
    localparam logic [4:0]  ENV_BOTTOM = 5'h00;

    typedef struct packed {
        logic cont;
        logic attack;
        logic alternate;
        logic hold;
    } t_env_flags;

    typedef struct packed {
        t_env_flags flags;
        logic [4:0] level;
    } t_env_state;

endpackage

`default_nettype wire

// ===== rtl/psg_env_step.sv =====
// One envelope step: moves the level along the ramp and applies the shape flags.
// Depends on psg_pkg for the envelope state type and level limits.
`default_nettype none

module psg_env_step (
    input  psg_pkg::t_env_state i_cur,
    output psg_pkg::t_env_state o_nxt
);

    logic       w_atk;
    logic [4:0] w_level;
    logic       w_at_end;

    assign w_atk = i_cur.flags.attack;

    always_comb begin
        if (w_atk) begin
            w_level = (i_cur.level != psg_pkg::ENV_TOP) ? i_cur.level + 5'd1 : i_cur.level;
        end else begin
            w_level = (i_cur.level != psg_pkg::ENV_BOTTOM) ? i_cur.level - 5'd1 : i_cur.level;
        end
        w_at_end = w_atk ? (w_level == psg_pkg::ENV_TOP) : (w_level == psg_pkg::ENV_BOTTOM);
    end

    always_comb begin
        o_nxt       = i_cur;
        o_nxt.level = w_level;
        if (w_at_end) begin
            if (!i_cur.flags.cont) begin
                o_nxt.level = w_atk ? psg_pkg::ENV_TOP : psg_pkg::ENV_BOTTOM;
            end else if (i_cur.flags.hold) begin
                o_nxt.level = w_level;
            end else if (i_cur.flags.alternate) begin
                o_nxt.flags.attack = !w_atk;
            end else begin
                o_nxt.level = w_atk ? psg_pkg::ENV_BOTTOM : psg_pkg::ENV_TOP;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/psg_tone_noise_envelope_core.sv =====
// Top level of the three-voice tone, noise and envelope sound generator core.
// Depends on psg_pkg and instantiates psg_env_step.
//
//   Channel | Direction | Handshake          | Payload
//   input   | in        | i_valid / o_ready  | i_func, i_reg_index, i_reg_value
//   result  | out       | o_valid / i_ready  | o_chan_*_bit, o_vol_*, o_env_out, o_noise_bit
//
// Every transfer on the input gives exactly one result in the next cycle.
// The state update and the result are one combinational pass into registers,
// so an item can be taken on every cycle unless i_ready stalls a full result register; that register sets the rate.
// The input is taken while the result register is empty or being emptied.
// Sync active-low reset sets all chip state, noise LFSR to ones; no clearing pass is needed.
`default_nettype none

module psg_tone_noise_envelope_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_func,
    input  wire  [3:0]  i_reg_index,
    input  wire  [7:0]  i_reg_value,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_chan_a_bit,
    output logic        o_chan_b_bit,
    output logic        o_chan_c_bit,
    output logic [4:0]  o_vol_a,
    output logic [4:0]  o_vol_b,
    output logic [4:0]  o_vol_c,
    output logic [4:0]  o_env_out,
    output logic        o_noise_bit
);

    logic [7:0]  r_regs [psg_pkg::NUM_REGS];
    logic [7:0]  n_regs [psg_pkg::NUM_REGS];
    logic [11:0] r_tone_cnt [psg_pkg::NUM_TONES];
    logic [11:0] n_tone_cnt [psg_pkg::NUM_TONES];
    logic [2:0]  r_tone_bits, n_tone_bits;
    logic [4:0]  r_noise_cnt, n_noise_cnt;
    logic [16:0] r_noise_shift, n_noise_shift;
    logic        r_noise_level, n_noise_level;
    logic [15:0] r_env_cnt, n_env_cnt;
    psg_pkg::t_env_state r_env, n_env, w_env_adv;

    logic        r_valid, n_valid;
    logic [2:0]  r_chan_bits, n_chan_bits;
    logic [4:0]  r_vol [psg_pkg::NUM_TONES];
    logic [4:0]  n_vol [psg_pkg::NUM_TONES];
    logic [4:0]  r_env_out;
    logic        r_noise_out;

    logic        w_accept;
    logic [11:0] w_tone_per;
    logic [11:0] w_tone_load;
    logic [4:0]  w_noise_per;
    logic [4:0]  w_noise_load;
    logic [15:0] w_env_per;
    logic [15:0] w_env_load;
    logic        w_env_fire;
    logic [7:0]  w_vreg;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    psg_env_step u_env_step (
        .i_cur (r_env),
        .o_nxt (w_env_adv)
    );

    always_comb begin
        n_regs        = r_regs;
        n_tone_cnt    = r_tone_cnt;
        n_tone_bits   = r_tone_bits;
        n_noise_cnt   = r_noise_cnt;
        n_noise_shift = r_noise_shift;
        n_noise_level = r_noise_level;
        n_env_cnt     = r_env_cnt;
        n_env         = r_env;
        w_tone_per    = '0;
        w_tone_load   = '0;
        w_noise_per   = '0;
        w_noise_load  = '0;
        w_env_per     = '0;
        w_env_load    = '0;
        w_env_fire    = 1'b0;

        if (psg_pkg::t_func'(i_func) == psg_pkg::FUNC_TICK) begin
            for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
                w_tone_per  = {r_regs[4'(2 * i + 1)][3:0], r_regs[4'(2 * i)]};
                w_tone_per  = (w_tone_per == 12'd0) ? 12'd1 : w_tone_per;
                w_tone_load = (r_tone_cnt[i] == 12'd0) ? w_tone_per : r_tone_cnt[i];
                n_tone_cnt[i] = w_tone_load - 12'd1;
                if (n_tone_cnt[i] == 12'd0) begin
                    n_tone_bits[i] = !r_tone_bits[i];
                end
            end

            w_noise_per  = r_regs[psg_pkg::REG_NOISE_PERIOD][4:0];
            w_noise_per  = (w_noise_per == 5'd0) ? 5'd1 : w_noise_per;
            w_noise_load = (r_noise_cnt == 5'd0) ? w_noise_per : r_noise_cnt;
            n_noise_cnt  = w_noise_load - 5'd1;
            if (n_noise_cnt == 5'd0) begin
                n_noise_shift = {r_noise_shift[0] ^ r_noise_shift[3], r_noise_shift[16:1]};
                n_noise_level = r_noise_shift[1];
            end

            w_env_per  = {r_regs[psg_pkg::REG_ENV_COARSE], r_regs[psg_pkg::REG_ENV_FINE]};
            w_env_per  = (w_env_per == 16'd0) ? 16'd1 : w_env_per;
            w_env_load = (r_env_cnt == 16'd0) ? w_env_per : r_env_cnt;
            n_env_cnt  = w_env_load - 16'd1;
            w_env_fire = (n_env_cnt == 16'd0);
            if (w_env_fire) begin
                n_env = w_env_adv;
            end
        end else begin
            n_regs[i_reg_index] = i_reg_value;
            if (i_reg_index == psg_pkg::REG_ENV_SHAPE) begin
                n_env.flags = psg_pkg::t_env_flags'(i_reg_value[3:0]);
                n_env.level = i_reg_value[2] ? psg_pkg::ENV_BOTTOM : psg_pkg::ENV_TOP;
            end
        end
    end

    always_comb begin
        w_vreg = '0;
        for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
            n_chan_bits[i] = 1'b1;
            if (!n_regs[psg_pkg::REG_MIXER][i]) begin
                n_chan_bits[i] = n_chan_bits[i] & n_tone_bits[i];
            end
            if (!n_regs[psg_pkg::REG_MIXER][i + 3]) begin
                n_chan_bits[i] = n_chan_bits[i] & !n_noise_level;
            end
            w_vreg   = n_regs[psg_pkg::REG_VOL_A + 4'(i)];
            n_vol[i] = w_vreg[4] ? n_env.level : {w_vreg[3:0], 1'b1};
        end
        n_valid = w_accept ? 1'b1 : (r_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psg_pkg::NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
                r_tone_cnt[i] <= '0;
            end
            r_tone_bits   <= '0;
            r_noise_cnt   <= '0;
            r_noise_shift <= psg_pkg::LFSR_RESET;
            r_noise_level <= 1'b1;
            r_env_cnt     <= '0;
            r_env         <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (w_accept) begin
                r_regs        <= n_regs;
                r_tone_cnt    <= n_tone_cnt;
                r_tone_bits   <= n_tone_bits;
                r_noise_cnt   <= n_noise_cnt;
                r_noise_shift <= n_noise_shift;
                r_noise_level <= n_noise_level;
                r_env_cnt     <= n_env_cnt;
                r_env         <= n_env;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chan_bits <= n_chan_bits;
            r_vol       <= n_vol;
            r_env_out   <= n_env.level;
            r_noise_out <= n_noise_level;
        end
    end

    assign o_valid      = r_valid;
    assign o_chan_a_bit = r_chan_bits[0];
    assign o_chan_b_bit = r_chan_bits[1];
    assign o_chan_c_bit = r_chan_bits[2];
    assign o_vol_a      = r_vol[0];
    assign o_vol_b      = r_vol[1];
    assign o_vol_c      = r_vol[2];
    assign o_env_out    = r_env_out;
    assign o_noise_bit  = r_noise_out;

    // The noise register can never lock up at all zeros.
    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise_shift != 17'd0)
        else $error("noise shift register reached zero");

    // The noise level always mirrors the low bit of the shift register.
    a_noise_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise_level == r_noise_shift[0])
        else $error("noise level out of step with shift register");

    // A shape write restarts the envelope at the end set by the attack bit.
    a_shape_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_func && i_reg_index == psg_pkg::REG_ENV_SHAPE)
        |=> (r_env.level == ($past(i_reg_value[2]) ? psg_pkg::ENV_BOTTOM : psg_pkg::ENV_TOP)))
        else $error("envelope did not restart after shape write");

    // Every transfer in is followed by a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("no result after input transfer");

    // The reported envelope level matches the state it came from.
    a_env_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept) && $past(i_rst_n) |-> (o_env_out == r_env.level))
        else $error("reported envelope level differs from state");

endmodule

`default_nettype wire
